@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro takes a label, a clock, a reset, an antecedent, a consequent
// and a message. They compile to nothing when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/rtcst_pkg.sv @@
`timescale 1ns / 1ps
package rtcst_pkg;

  // Consecutive failed reads before the decoder gives up.
  localparam int MAX_ATTEMPTS = 3;

  // Register bit positions.
  localparam int UIP_BIT  = 7;
  localparam int MODE_24H = 1;
  localparam int MODE_BIN = 2;
  localparam logic [7:0] HOUR_MASK = 8'h7f;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RETRY   = 3'd1,
    ST_BAD_BCD = 3'd2,
    ST_BAD_12H = 3'd3,
    ST_RANGE   = 3'd4,
    ST_GAVE_UP = 3'd5
  } status_t;

  // Classified snapshot, decoded to binary, as passed from front to back.
  typedef struct packed {
    status_t     status;
    logic [7:0]  year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stamp_rec_t;

  // Two decimal digits of a value below 100.
  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_pair_t;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Text stamp layout: YYYYMMDDhhmmssZ.
  localparam int STAMP_LEN = 15;
  localparam int IDX_W = $clog2(STAMP_LEN);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAMP_LEN - 1);
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_Z = 8'h5a;
  localparam logic [3:0] YEAR_THOUSANDS = 4'd2;

  // Index positions within the stamp.
  localparam logic [IDX_W-1:0] POS_YH = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_YT = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_YO = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_MT = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_MO = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_DT = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_DO = IDX_W'(7);
  localparam logic [IDX_W-1:0] POS_HT = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_HO = IDX_W'(9);
  localparam logic [IDX_W-1:0] POS_NT = IDX_W'(10);
  localparam logic [IDX_W-1:0] POS_NO = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_ST = IDX_W'(12);
  localparam logic [IDX_W-1:0] POS_SO = IDX_W'(13);

  // True when both nibbles are decimal digits.
  function automatic logic bcd_ok(input logic [7:0] raw);
    return (raw[3:0] <= 4'd9) && (raw[7:4] <= 4'd9);
  endfunction

  // Value of a BCD byte: high nibble times ten plus low nibble.
  function automatic logic [6:0] bcd_val(input logic [7:0] raw);
    return 7'({raw[7:4], 3'b000}) + 7'({raw[7:4], 1'b0}) + 7'(raw[3:0]);
  endfunction

  // Days in a month, with the leap flag applied to February.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    case (m) inside
      4'd2: d = 5'd28 + 5'(leap);
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

  // Splits a value below 100 into decimal digits; x*205>>11 is x/10 here.
  function automatic dec_pair_t split_tens(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  rem;
    dec_pair_t   p;
    prod = 15'(v) * 15'd205;
    t = prod[14:11];
    rem = v - 7'({t, 3'b000}) - 7'({t, 1'b0});
    p.tens = t;
    p.ones = rem[3:0];
    return p;
  endfunction

endpackage

@@ rtl/rtcst_if.sv @@
`timescale 1ns / 1ps
// Snapshot channel: one clock read attempt per item.
interface rtcst_snap_if;
  logic       valid;
  logic       ready;
  logic [7:0] status_a_before;
  logic [7:0] seconds_raw;
  logic [7:0] minutes_raw;
  logic [7:0] hours_raw;
  logic [7:0] day_raw;
  logic [7:0] month_raw;
  logic [7:0] year_raw;
  logic [7:0] status_reg_b;
  logic [7:0] seconds_again;
  logic [7:0] status_a_after;

  modport source (
    output valid, status_a_before, seconds_raw, minutes_raw, hours_raw, day_raw,
           month_raw, year_raw, status_reg_b, seconds_again, status_a_after,
    input  ready
  );
  modport sink (
    input  valid, status_a_before, seconds_raw, minutes_raw, hours_raw, day_raw,
           month_raw, year_raw, status_reg_b, seconds_again, status_a_after,
    output ready
  );
endinterface

// Stamp channel: one character or one status per item.
interface rtcst_stamp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] character;
  logic       last;

  modport source (output valid, status, character, last, input ready);
  modport sink (input valid, status, character, last, output ready);
endinterface

@@ rtl/rtc_snapshot_to_utc_text.sv @@
`timescale 1ns / 1ps
// CMOS clock snapshot decoder with UTC text output.
// snapshot channel: one item per read attempt of the clock chip (status A
// before and after, raw time fields, status B, seconds read again).
// stamp channel: per snapshot either fifteen items carrying the characters
// YYYYMMDDhhmmssZ with status ok, last set on the Z, or a single item with
// a retry, gave-up or decode error status, character zero and last set.
// Three consecutive failed reads give the gave-up status and clear the count.
// The first result passes through the queue entry and then the output
// register of the back end before it is presented. A successful snapshot
// gives fifteen output items and a failed one a single item; the output
// register of the back end sends one character per cycle while the
// receiver does not stall. A two-entry queue sits between the front end,
// which classifies and decodes a snapshot in the cycle it is taken, and the
// back end, so snapshots are taken while a stamp is still being sent.
// Reset clears the failure count, the queue and the output sequencer.
// When the receiver stalls the current result holds; the queue then fills
// and snapshot ready drops until room frees up.
module rtc_snapshot_to_utc_text (
  input  logic          clk,
  input  logic          rst,
  rtcst_snap_if.sink    snapshot,
  rtcst_stamp_if.source stamp
);
  import rtcst_pkg::*;

  logic       q_full;
  logic       push;
  stamp_rec_t wr_rec;
  logic       pop;
  logic       head_valid;
  stamp_rec_t head;

  rtcst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .snapshot (snapshot),
    .q_full   (q_full),
    .push     (push),
    .rec      (wr_rec)
  );

  rtcst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_rec     (wr_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rtcst_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .stamp      (stamp)
  );

endmodule

@@ rtl/rtcst_front.sv @@
`timescale 1ns / 1ps
module rtcst_front (
  input  logic                clk,
  input  logic                rst,
  rtcst_snap_if.sink          snapshot,
  input  logic                q_full,
  output logic                push,
  output rtcst_pkg::stamp_rec_t rec
);
  import rtcst_pkg::*;

  logic [1:0] failed_attempts;
  logic [1:0] failed_attempts_next;
  logic [1:0] fail_count;
  logic       read_bad;
  logic       bin_mode;
  logic       mode_24h;
  logic       pm;
  logic [7:0] hour_strip;
  logic       bcd_bad;
  logic [7:0] sec_v;
  logic [7:0] min_v;
  logic [7:0] hr_v;
  logic [7:0] day_v;
  logic [7:0] mon_v;
  logic [7:0] yr_v;
  logic       h12_bad;
  logic [7:0] hr_c;
  logic       leap;
  logic       range_bad;
  status_t    status;

  // Items are taken whenever the queue has room.
  assign snapshot.ready = !q_full;
  assign push = snapshot.valid && !q_full;

  // A busy flag on either side or a seconds mismatch spoils the read.
  assign read_bad = snapshot.status_a_before[UIP_BIT] || snapshot.status_a_after[UIP_BIT]
                    || (snapshot.seconds_raw != snapshot.seconds_again);
  assign fail_count = failed_attempts + 2'd1;

  assign bin_mode   = snapshot.status_reg_b[MODE_BIN];
  assign mode_24h   = snapshot.status_reg_b[MODE_24H];
  assign pm         = snapshot.hours_raw[UIP_BIT];
  assign hour_strip = snapshot.hours_raw & HOUR_MASK;

  // BCD check and decode of all six fields.
  assign bcd_bad = !bin_mode && !(bcd_ok(snapshot.seconds_raw) && bcd_ok(snapshot.minutes_raw)
                   && bcd_ok(hour_strip) && bcd_ok(snapshot.day_raw)
                   && bcd_ok(snapshot.month_raw) && bcd_ok(snapshot.year_raw));
  assign sec_v = bin_mode ? snapshot.seconds_raw : {1'b0, bcd_val(snapshot.seconds_raw)};
  assign min_v = bin_mode ? snapshot.minutes_raw : {1'b0, bcd_val(snapshot.minutes_raw)};
  assign hr_v  = bin_mode ? hour_strip : {1'b0, bcd_val(hour_strip)};
  assign day_v = bin_mode ? snapshot.day_raw : {1'b0, bcd_val(snapshot.day_raw)};
  assign mon_v = bin_mode ? snapshot.month_raw : {1'b0, bcd_val(snapshot.month_raw)};
  assign yr_v  = bin_mode ? snapshot.year_raw : {1'b0, bcd_val(snapshot.year_raw)};

  // 12-hour check and conversion to 24-hour time.
  assign h12_bad = !mode_24h && ((hr_v == 8'd0) || (hr_v > 8'd12));
  always_comb begin
    hr_c = hr_v;
    if (!mode_24h) begin
      if (pm) begin
        if (hr_v != 8'd12) begin
          hr_c = hr_v + 8'd12;
        end
      end else if (hr_v == 8'd12) begin
        hr_c = 8'd0;
      end
    end
  end

  // Years 2000 + 0..255: 2100 and 2200 are the only century years that are not leap.
  assign leap = (yr_v[1:0] == 2'b00) && (yr_v != 8'd100) && (yr_v != 8'd200);
  assign range_bad = (sec_v > 8'd59) || (min_v > 8'd59) || (hr_c > 8'd23)
                     || (mon_v == 8'd0) || (mon_v > 8'd12) || (day_v == 8'd0)
                     || (day_v > {3'b000, month_days(mon_v[3:0], leap)});

  // Classification in priority order, and the next failure count.
  always_comb begin
    failed_attempts_next = 2'd0;
    if (read_bad) begin
      if (32'(fail_count) >= MAX_ATTEMPTS) begin
        status = ST_GAVE_UP;
      end else begin
        status = ST_RETRY;
        failed_attempts_next = fail_count;
      end
    end else if (bcd_bad) begin
      status = ST_BAD_BCD;
    end else if (h12_bad) begin
      status = ST_BAD_12H;
    end else if (range_bad) begin
      status = ST_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  // Record for the back end.
  always_comb begin
    rec.status = status;
    rec.year   = yr_v;
    rec.month  = mon_v[3:0];
    rec.day    = day_v[4:0];
    rec.hour   = hr_c[4:0];
    rec.minute = min_v[5:0];
    rec.second = sec_v[5:0];
  end

  // Failure count is updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      failed_attempts <= 2'd0;
    end else if (push) begin
      failed_attempts <= failed_attempts_next;
    end
  end

endmodule

@@ rtl/rtcst_queue.sv @@
`timescale 1ns / 1ps
module rtcst_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rtcst_pkg::stamp_rec_t wr_rec,
  output logic                  full,
  input  logic                  pop,
  output logic                  head_valid,
  output rtcst_pkg::stamp_rec_t head
);
  import rtcst_pkg::*;

  stamp_rec_t          entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10: count <= count + QCNT_W'(1);
        2'b01: count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/rtcst_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rtcst_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  rtcst_pkg::stamp_rec_t head,
  output logic                  pop,
  rtcst_stamp_if.source         stamp
);
  import rtcst_pkg::*;

  logic             o_valid;
  status_t          o_status;
  logic [7:0]       o_char;
  logic             o_last;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             advance;

  logic [3:0]       year_hund;
  dec_pair_t        year_pair;
  dec_pair_t        month_pair;
  dec_pair_t        day_pair;
  dec_pair_t        hour_pair;
  dec_pair_t        minute_pair;
  dec_pair_t        second_pair;

  logic [3:0]       head_hund;
  logic [7:0]       head_yrem;
  logic [3:0]       nib;
  logic [7:0]       busy_char;

  assign stamp.valid     = o_valid;
  assign stamp.status    = o_status;
  assign stamp.character = o_char;
  assign stamp.last      = o_last;

  // The output register moves when empty or when its item is taken.
  assign advance = !o_valid || stamp.ready;
  assign pop     = advance && !busy && head_valid;

  // Year 2000 + value: split off the hundreds, the rest is below 100.
  always_comb begin
    if (head.year >= 8'd200) begin
      head_hund = 4'd2;
      head_yrem = head.year - 8'd200;
    end else if (head.year >= 8'd100) begin
      head_hund = 4'd1;
      head_yrem = head.year - 8'd100;
    end else begin
      head_hund = 4'd0;
      head_yrem = head.year;
    end
  end

  // Digit for the current stamp position.
  always_comb begin
    case (idx)
      POS_YH:  nib = year_hund;
      POS_YT:  nib = year_pair.tens;
      POS_YO:  nib = year_pair.ones;
      POS_MT:  nib = month_pair.tens;
      POS_MO:  nib = month_pair.ones;
      POS_DT:  nib = day_pair.tens;
      POS_DO:  nib = day_pair.ones;
      POS_HT:  nib = hour_pair.tens;
      POS_HO:  nib = hour_pair.ones;
      POS_NT:  nib = minute_pair.tens;
      POS_NO:  nib = minute_pair.ones;
      POS_ST:  nib = second_pair.tens;
      POS_SO:  nib = second_pair.ones;
      default: nib = 4'd0;
    endcase
  end
  assign busy_char = (idx == LAST_IDX) ? CHAR_Z : CHAR_ZERO + {4'b0000, nib};

  // Digits are captured when a successful record starts.
  always_ff @(posedge clk) begin
    if (pop && (head.status == ST_OK)) begin
      year_hund   <= head_hund;
      year_pair   <= split_tens(head_yrem[6:0]);
      month_pair  <= split_tens({3'b000, head.month});
      day_pair    <= split_tens({2'b00, head.day});
      hour_pair   <= split_tens({2'b00, head.hour});
      minute_pair <= split_tens({1'b0, head.minute});
      second_pair <= split_tens({1'b0, head.second});
    end
  end

  // Output sequencing: first character or single status at pop, then the rest.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      busy    <= 1'b0;
      idx     <= '0;
    end else if (advance) begin
      if (busy) begin
        o_valid  <= 1'b1;
        o_status <= ST_OK;
        o_char   <= busy_char;
        o_last   <= (idx == LAST_IDX);
        busy     <= (idx != LAST_IDX);
        idx      <= idx + IDX_W'(1);
      end else if (head_valid) begin
        o_valid  <= 1'b1;
        o_status <= head.status;
        if (head.status == ST_OK) begin
          o_char <= CHAR_ZERO + {4'b0000, YEAR_THOUSANDS};
          o_last <= 1'b0;
          busy   <= 1'b1;
          idx    <= POS_YH;
        end else begin
          o_char <= 8'h00;
          o_last <= 1'b1;
        end
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_err_single, clk, rst, o_valid && (o_status != ST_OK), o_last && (o_char == 8'h00), "error result must be a single item with no character")
  `ASSERT_IMPLIES(a_ok_ends_z, clk, rst, o_valid && (o_status == ST_OK) && o_last, o_char == CHAR_Z, "final stamp character must be Z")
  `ASSERT_IMPLIES(a_idx_range, clk, rst, busy, (idx != '0) && (idx <= LAST_IDX), "stamp index out of range while busy")
  `ASSERT_NEXT(a_start_seq, clk, rst, pop && (head.status == ST_OK), busy && o_valid && !o_last, "successful record must start a stamp sequence")

endmodule
